// ----- rtl/ttip_pkg.sv -----
`default_nettype none

package ttip_pkg;

   // Field widths fixed by the interface
   localparam int CH_BITS          = 8;
   localparam int BASE_BITS        = 6;
   localparam int DIGIT_BITS       = 6;
   localparam int VALUE_BITS       = 64;
   localparam int END_BITS         = 16;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 6;
   localparam int PROD_BITS        = VALUE_BITS + BASE_BITS + 1;
   localparam int OFFSET_BITS_DEFAULT = 16;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_SETTING = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIGNED_MODE  = 2'd1;

   // Register reset values
   localparam logic [BASE_BITS-1:0] BASE_SETTING_RESET = 6'd0;
   localparam logic                 SIGNED_MODE_RESET  = 1'b1;

   // Bases
   localparam logic [BASE_BITS-1:0] BASE_OCT     = 6'd8;
   localparam logic [BASE_BITS-1:0] BASE_DEC     = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_HEX     = 6'd16;
   localparam logic [BASE_BITS-1:0] BASE_MIN     = 6'd2;
   localparam logic [BASE_BITS-1:0] BASE_MAX     = 6'd36;
   localparam logic [DIGIT_BITS-1:0] DIGIT_NONE  = 6'd36;

   // Limits
   localparam logic [VALUE_BITS-1:0] SIGNED_MAX_VALUE   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_BITS-1:0] SIGNED_MIN_VALUE   = 64'h8000_0000_0000_0000;
   localparam logic [VALUE_BITS-1:0] UNSIGNED_MAX_VALUE = 64'hFFFF_FFFF_FFFF_FFFF;

   // Characters
   localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_BITS-1:0] CH_HT    = 8'h09;
   localparam logic [CH_BITS-1:0] CH_CR    = 8'h0D;
   localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_BITS-1:0] CH_0     = 8'h30;
   localparam logic [CH_BITS-1:0] CH_9     = 8'h39;
   localparam logic [CH_BITS-1:0] CH_UA    = 8'h41;
   localparam logic [CH_BITS-1:0] CH_UZ    = 8'h5A;
   localparam logic [CH_BITS-1:0] CH_LA    = 8'h61;
   localparam logic [CH_BITS-1:0] CH_LZ    = 8'h7A;
   localparam logic [CH_BITS-1:0] CH_UX    = 8'h58;
   localparam logic [CH_BITS-1:0] CH_LX    = 8'h78;

   // Parser phase
   typedef enum logic [5:0] {
      PH_WS     = 6'b000001,
      PH_SIGNED = 6'b000010,
      PH_ZERO   = 6'b000100,
      PH_HEXPFX = 6'b001000,
      PH_DIGITS = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   // Per-string conversion state (offset counters live beside it)
   typedef struct packed {
      phase_type              phase;
      logic [VALUE_BITS-1:0]  acc;
      logic                   neg;
      logic                   ovf;
      logic                   seen;
      logic [BASE_BITS-1:0]   wbase;
   } state_type;

   localparam state_type STATE_START = '{
      phase: PH_WS,
      acc:   '0,
      neg:   1'b0,
      ovf:   1'b0,
      seen:  1'b0,
      wbase: BASE_DEC
   };

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  overflow;
      logic                  converted;
      logic [END_BITS-1:0]   end_offset;
   } result_type;

   // Digit value of a character, DIGIT_NONE for anything else
   function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CH_BITS-1:0] c);
      logic [CH_BITS-1:0] v;
      v = {2'b00, DIGIT_NONE};
      if (c inside {[CH_0:CH_9]}) begin
         v = c - CH_0;
      end else if (c inside {[CH_UA:CH_UZ]}) begin
         v = c - CH_UA + 8'd10;
      end else if (c inside {[CH_LA:CH_LZ]}) begin
         v = c - CH_LA + 8'd10;
      end
      return v[DIGIT_BITS-1:0];
   endfunction

   // Out-of-range working base falls back to decimal
   function automatic logic [BASE_BITS-1:0] eff_base(input logic [BASE_BITS-1:0] b);
      return (b < BASE_MIN || b > BASE_MAX) ? BASE_DEC : b;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ttip_step.sv -----
`default_nettype none

module ttip_step #(
   parameter int OFFSET_BITS = ttip_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic [ttip_pkg::BASE_BITS-1:0] base_setting,
   input  wire logic                           signed_mode,
   input  wire logic [ttip_pkg::CH_BITS-1:0]   ch,
   input  wire logic                           first,
   input  wire ttip_pkg::state_type            state_q,
   input  wire logic [OFFSET_BITS-1:0]         count_q,
   input  wire logic [OFFSET_BITS-1:0]         last_q,
   output ttip_pkg::state_type                 state_d,
   output logic [OFFSET_BITS-1:0]              count_d,
   output logic [OFFSET_BITS-1:0]              last_d,
   output logic                                fin,
   output ttip_pkg::result_type                result
);
   import ttip_pkg::*;

   state_type             cur;
   logic [OFFSET_BITS-1:0] cur_count;
   logic [OFFSET_BITS-1:0] cur_last;
   logic [DIGIT_BITS-1:0] d;
   logic                  autob;
   logic                  lead_zero;
   logic [BASE_BITS-1:0]  wb_start;
   logic [BASE_BITS-1:0]  wb_zero;
   logic [BASE_BITS-1:0]  cur_eff;
   logic [BASE_BITS-1:0]  acc_base;
   logic [VALUE_BITS-1:0] limit;
   logic [PROD_BITS-1:0]  prod;
   logic                  over;
   logic                  num_start;
   logic                  do_acc;
   logic [END_BITS-1:0]   end_sat;

   // A string start restarts the conversion before this character is looked at
   assign cur       = first ? STATE_START : state_q;
   assign cur_count = first ? '0 : count_q;
   assign cur_last  = first ? '0 : last_q;

   assign d         = digit_of(ch);
   assign autob     = base_setting < BASE_MIN;
   assign lead_zero = (ch == CH_0) && (autob || base_setting == BASE_HEX);
   assign wb_start  = autob ? BASE_DEC : base_setting;
   assign wb_zero   = autob ? BASE_OCT : BASE_HEX;
   assign cur_eff   = eff_base(cur.wbase);

   // Base used by the multiply-add this cycle
   always_comb begin
      if (cur.phase == PH_WS || cur.phase == PH_SIGNED) begin
         acc_base = lead_zero ? wb_zero : wb_start;
      end else begin
         acc_base = cur_eff;
      end
   end

   // Multiply-add with saturation check against the type limit
   always_comb begin
      if (signed_mode) begin
         limit = cur.neg ? SIGNED_MIN_VALUE : SIGNED_MAX_VALUE;
      end else begin
         limit = UNSIGNED_MAX_VALUE;
      end
      prod = PROD_BITS'(cur.acc) * PROD_BITS'(acc_base) + PROD_BITS'(d);
      over = prod > PROD_BITS'(limit);
   end

   // Phase sequencing
   always_comb begin
      state_d   = cur;
      count_d   = cur_count;
      last_d    = cur_last;
      num_start = 1'b0;
      do_acc    = 1'b0;
      fin       = 1'b0;
      if (cur.phase != PH_DONE) begin
         count_d = (&cur_count) ? cur_count : cur_count + 1'b1;
         case (cur.phase)
            PH_WS: begin
               if (ch == CH_SPACE || ch inside {[CH_HT:CH_CR]}) begin
                  state_d.phase = PH_WS;
               end else if (ch == CH_MINUS) begin
                  state_d.neg   = 1'b1;
                  state_d.phase = PH_SIGNED;
               end else if (ch == CH_PLUS) begin
                  state_d.phase = PH_SIGNED;
               end else begin
                  num_start = 1'b1;
               end
            end
            PH_SIGNED: begin
               num_start = 1'b1;
            end
            PH_ZERO: begin
               if (ch == CH_LX || ch == CH_UX) begin
                  state_d.wbase = BASE_HEX;
                  state_d.phase = PH_HEXPFX;
               end else begin
                  state_d.phase = PH_DIGITS;
                  if (d < cur_eff) begin
                     do_acc = 1'b1;
                  end else begin
                     fin = 1'b1;
                  end
               end
            end
            PH_HEXPFX: begin
               if (d < BASE_HEX) begin
                  do_acc        = 1'b1;
                  state_d.phase = PH_DIGITS;
               end else begin
                  fin = 1'b1;
               end
            end
            PH_DIGITS: begin
               if (d < cur_eff) begin
                  do_acc = 1'b1;
               end else begin
                  fin = 1'b1;
               end
            end
            default: begin
            end
         endcase

         // First character of the number: latch the base
         if (num_start) begin
            if (base_setting > BASE_MAX) begin
               fin = 1'b1;
            end else if (lead_zero) begin
               state_d.wbase = wb_zero;
               state_d.phase = PH_ZERO;
               do_acc        = 1'b1;
            end else if (d < wb_start) begin
               state_d.wbase = wb_start;
               state_d.phase = PH_DIGITS;
               do_acc        = 1'b1;
            end else begin
               state_d.wbase = wb_start;
               fin           = 1'b1;
            end
         end

         // Accumulate; digits past saturation are consumed only
         if (do_acc) begin
            last_d       = count_d;
            state_d.seen = 1'b1;
            if (!cur.ovf) begin
               if (over) begin
                  state_d.ovf = 1'b1;
               end else begin
                  state_d.acc = prod[VALUE_BITS-1:0];
               end
            end
         end

         if (fin) begin
            state_d.phase = PH_DONE;
         end
      end
   end

   // End offset saturates at the field width
   generate
      if (OFFSET_BITS > END_BITS) begin : g_end_sat
         assign end_sat = (|cur_last[OFFSET_BITS-1:END_BITS]) ? '1 : cur_last[END_BITS-1:0];
      end else begin : g_end_ext
         assign end_sat = END_BITS'(cur_last);
      end
   endgenerate

   // Result of a finished string
   always_comb begin
      result.overflow   = cur.seen & cur.ovf;
      result.converted  = cur.seen;
      result.end_offset = cur.seen ? end_sat : '0;
      if (!cur.seen) begin
         result.value = '0;
      end else if (cur.ovf) begin
         if (signed_mode) begin
            result.value = cur.neg ? SIGNED_MIN_VALUE : SIGNED_MAX_VALUE;
         end else begin
            result.value = UNSIGNED_MAX_VALUE;
         end
      end else begin
         result.value = cur.neg ? (VALUE_BITS'(0) - cur.acc) : cur.acc;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/text_to_integer_parser_unit.sv -----
`default_nettype none

// Channel   | Direction | Handshake        | Payload
// ----------+-----------+------------------+-------------------------------------------
// req_      | in        | valid / stall    | ch[7:0], first
// rsp_      | out       | valid / stall    | value[63:0], overflow, converted,
//           |           |                  | end_offset[15:0]
// csr_      | in        | valid / ready    | index[1:0], data[5:0]
//
// One character per cycle while the response does not stall. A request is captured in
// the input register, converted by a single 64x6 multiply-add and limit compare, and
// its result (if it ends the number) lands in the response register.
// Reset is synchronous and restores the register defaults and the string-start state.
// A stalled response holds the pipe only when the input register also has a request.

module text_to_integer_parser_unit #(
   parameter int OFFSET_BITS = ttip_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [ttip_pkg::CH_BITS-1:0]        req_ch,
   input  wire logic                                req_first,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [ttip_pkg::VALUE_BITS-1:0]          rsp_value,
   output logic                                     rsp_overflow,
   output logic                                     rsp_converted,
   output logic [ttip_pkg::END_BITS-1:0]            rsp_end_offset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ttip_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ttip_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import ttip_pkg::*;

   logic [BASE_BITS-1:0]   base_ff;
   logic                   smode_ff;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [CH_BITS-1:0]     in_ch_ff;
   logic                   in_first_ff;
   state_type              state_ff;
   state_type              state_in;
   logic [OFFSET_BITS-1:0] count_ff;
   logic [OFFSET_BITS-1:0] count_in;
   logic [OFFSET_BITS-1:0] last_ff;
   logic [OFFSET_BITS-1:0] last_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   result_type             rsp_ff;
   result_type             result;
   logic                   fin;
   logic                   adv;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_SETTING_RESET;
         smode_ff <= SIGNED_MODE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE_SETTING: base_ff  <= csr_data[BASE_BITS-1:0];
            CSR_SIGNED_MODE:  smode_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Flow control: the input register moves on when the response slot is free
   assign adv          = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !adv;
   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;

   always_comb begin
      if (adv) begin
         rsp_valid_in = fin;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Conversion step
   ttip_step #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_step (
      .base_setting (base_ff),
      .signed_mode  (smode_ff),
      .ch           (in_ch_ff),
      .first        (in_first_ff),
      .state_q      (state_ff),
      .count_q      (count_ff),
      .last_q       (last_ff),
      .state_d      (state_in),
      .count_d      (count_in),
      .last_d       (last_in),
      .fin          (fin),
      .result       (result)
   );

   // Control and conversion state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_START;
         count_ff     <= '0;
         last_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            state_ff <= state_in;
            count_ff <= count_in;
            last_ff  <= last_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ch_ff    <= req_ch;
         in_first_ff <= req_first;
      end
      if (adv && fin) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_ff.value;
   assign rsp_overflow   = rsp_ff.overflow;
   assign rsp_converted  = rsp_ff.converted;
   assign rsp_end_offset = rsp_ff.end_offset;

endmodule

`default_nettype wire
